>>> src/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_STR  = 5'b00010,
    MODE_ESC  = 5'b00100,
    MODE_HEX  = 5'b01000,
    MODE_ERR  = 5'b10000
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [1:0] HEX_LAST  = 2'd3;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0]} + 5'd9;
    end
    return v;
  endfunction

endpackage

>>> src/jsu_in_if.sv
`timescale 1ns / 1ps

interface jsu_in_if import jsu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

>>> src/jsu_out_if.sv
`timescale 1ns / 1ps

interface jsu_out_if import jsu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  kind_t      kind;
  logic       last_of_run;

  modport source (output valid, output out_byte, output kind, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input kind, input last_of_run,
                  output ready);
endinterface

>>> src/json_string_unescape_utf8.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                          Handshake
// in_ch    in   in_byte[7:0], end_of_text        valid/ready
// out_ch   out  out_byte[7:0], kind, last_of_run valid/ready
//
// One request is decoded in the cycle it is taken; its results sit in a
// three-entry result register and leave one per cycle while out_ch is ready,
// from the next cycle on. A new request is taken while the last pending result
// is being taken, so a one-result request streams at one per cycle while
// out_ch is ready; a \u request holds in_ch until its last byte is taken.
// Reset (rst_n low, synchronous) returns to idle with no pending results.
// Stalls on out_ch hold the result register and back-pressure in_ch.

module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [15:0] acc_r, acc_nxt;

  logic [1:0]  rem_r;
  logic [7:0]  b0_r, b1_r, b2_r;
  kind_t       kind_r;

  logic [1:0]  res_n;
  logic [7:0]  res_b0, res_b1, res_b2;
  kind_t       res_kind;

  logic        in_fire, out_fire;
  logic [7:0]  c;
  logic [4:0]  hv;
  logic [15:0] acc_sh;

  assign c        = in_ch.in_byte;
  assign hv       = hex_value(c);
  assign acc_sh   = {acc_r[11:0], hv[3:0]};

  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (rem_r == 2'd0) || (rem_r == 2'd1 && out_ch.ready);
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = (rem_r != 2'd0);
  assign out_ch.out_byte    = b0_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.last_of_run = (rem_r == 2'd1);

  always_comb begin
    mode_nxt = mode_r;
    hcnt_nxt = hcnt_r;
    acc_nxt  = acc_r;
    res_n    = 2'd0;
    res_kind = KIND_BYTE;
    res_b0   = 8'h00;
    res_b1   = 8'h00;
    res_b2   = 8'h00;
    if (in_ch.end_of_text) begin
      mode_nxt = MODE_IDLE;
      hcnt_nxt = 2'd0;
      acc_nxt  = 16'h0000;
      if (mode_r == MODE_STR || mode_r == MODE_ESC || mode_r == MODE_HEX) begin
        res_n    = 2'd1;
        res_kind = KIND_ERR;
      end
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (c == CH_QUOTE) begin
            mode_nxt = MODE_STR;
          end else if (!is_space(c)) begin
            mode_nxt = MODE_ERR;
            res_n    = 2'd1;
            res_kind = KIND_ERR;
          end
        end
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
            res_n    = 2'd1;
            res_kind = KIND_DONE;
          end else if (c < CH_SPACE) begin
            mode_nxt = MODE_ERR;
            res_n    = 2'd1;
            res_kind = KIND_ERR;
          end else if (c == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            res_n  = 2'd1;
            res_b0 = c;
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_STR;
          res_n    = 2'd1;
          case (c)
            CH_QUOTE:  res_b0 = CH_QUOTE;
            CH_BSLASH: res_b0 = CH_BSLASH;
            CH_SLASH:  res_b0 = CH_SLASH;
            CH_B:      res_b0 = 8'h08;
            CH_F:      res_b0 = 8'h0C;
            CH_N:      res_b0 = 8'h0A;
            CH_R:      res_b0 = 8'h0D;
            CH_T:      res_b0 = 8'h09;
            CH_U: begin
              mode_nxt = MODE_HEX;
              hcnt_nxt = 2'd0;
              acc_nxt  = 16'h0000;
              res_n    = 2'd0;
            end
            default: begin
              mode_nxt = MODE_ERR;
              res_kind = KIND_ERR;
            end
          endcase
        end
        MODE_HEX: begin
          if (hv[4]) begin
            mode_nxt = MODE_ERR;
            res_n    = 2'd1;
            res_kind = KIND_ERR;
          end else begin
            acc_nxt = acc_sh;
            if (hcnt_r != HEX_LAST) begin
              hcnt_nxt = hcnt_r + 2'd1;
            end else begin
              hcnt_nxt = 2'd0;
              if (acc_sh[15:11] == 5'b11011) begin
                mode_nxt = MODE_ERR;
                res_n    = 2'd1;
                res_kind = KIND_ERR;
              end else begin
                mode_nxt = MODE_STR;
                if (acc_sh[15:7] == 9'd0) begin
                  res_n  = 2'd1;
                  res_b0 = {1'b0, acc_sh[6:0]};
                end else if (acc_sh[15:11] == 5'd0) begin
                  res_n  = 2'd2;
                  res_b0 = {3'b110, acc_sh[10:6]};
                  res_b1 = {2'b10, acc_sh[5:0]};
                end else begin
                  res_n  = 2'd3;
                  res_b0 = {4'b1110, acc_sh[15:12]};
                  res_b1 = {2'b10, acc_sh[11:6]};
                  res_b2 = {2'b10, acc_sh[5:0]};
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      hcnt_r <= 2'd0;
      acc_r  <= 16'h0000;
      rem_r  <= 2'd0;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      hcnt_r <= hcnt_nxt;
      acc_r  <= acc_nxt;
      rem_r  <= res_n;
    end else if (out_fire) begin
      rem_r  <= rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b0_r   <= res_b0;
      b1_r   <= res_b1;
      b2_r   <= res_b2;
      kind_r <= res_kind;
    end else if (out_fire) begin
      b0_r <= b1_r;
      b1_r <= b2_r;
    end
  end

`ifndef SYNTH
  a_take_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !out_ch.valid || (out_ch.ready && out_ch.last_of_run))
    else $error("request taken while results still pending");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_ch.last_of_run |=> out_ch.valid)
    else $error("result run broken");

  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind != KIND_BYTE |-> out_ch.out_byte == 8'h00
      && out_ch.last_of_run)
    else $error("status result carries byte or is not last");

  a_hex_count_mode: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r != 2'd0 |-> mode_r == MODE_HEX || mode_r == MODE_ERR)
    else $error("hex count set outside hex mode");
`endif

endmodule

>>> tb/sv/json_string_unescape_utf8_tb.sv
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  localparam int N_DIRECTED   = 25;
  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 16;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 150;
  localparam logic [8:0] NO_ESCAPE = 9'h100;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    int         typed_n;   // -1: predictor decides; else 0 or 1 results typed below
    kind_t      tkind;
    logic [7:0] tval;
  } text_item_t;

  typedef struct packed {
    logic [7:0] value;
    kind_t      kind;
    logic       last;
  } result_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  text_item_t text_q[$];
  result_t    decoded_q[$];
  result_t    fresh[$];
  int         live_items = 0;
  int         taken = 0;
  int         failures = 0;
  int         n_bytes = 0;
  int         n_closed = 0;
  int         n_errors = 0;
  int         stalled_cycles = 0;

  // decoder state
  mode_t       dec_mode = MODE_IDLE;
  logic [1:0]  hex_taken = '0;
  logic [15:0] code_pt = '0;

  text_item_t directed_rows [N_DIRECTED] = '{
    '{CH_SPACE,  1'b0,  0, KIND_BYTE, 8'h00},
    '{CH_QUOTE,  1'b0,  0, KIND_BYTE, 8'h00},
    '{8'hFF,     1'b0,  1, KIND_BYTE, 8'hFF},
    '{CH_BSLASH, 1'b0,  0, KIND_BYTE, 8'h00},
    '{CH_U,      1'b0,  0, KIND_BYTE, 8'h00},
    '{8'h30,     1'b0,  0, KIND_BYTE, 8'h00},
    '{8'h30,     1'b0,  0, KIND_BYTE, 8'h00},
    '{8'h30,     1'b0,  0, KIND_BYTE, 8'h00},
    '{8'h30,     1'b0,  1, KIND_BYTE, 8'h00},
    '{CH_BSLASH, 1'b0,  0, KIND_BYTE, 8'h00},
    '{CH_U,      1'b0,  0, KIND_BYTE, 8'h00},
    '{8'h46,     1'b0,  0, KIND_BYTE, 8'h00},
    '{8'h66,     1'b0,  0, KIND_BYTE, 8'h00},
    '{8'h46,     1'b0,  0, KIND_BYTE, 8'h00},
    '{8'h64,     1'b0, -1, KIND_BYTE, 8'h00},
    '{CH_QUOTE,  1'b0,  1, KIND_DONE, 8'h00},
    '{8'h78,     1'b0,  1, KIND_ERR,  8'h00},
    '{8'h80,     1'b0,  0, KIND_BYTE, 8'h00},
    '{8'h00,     1'b1,  0, KIND_BYTE, 8'h00},
    '{CH_QUOTE,  1'b0,  0, KIND_BYTE, 8'h00},
    '{8'hFF,     1'b1,  1, KIND_ERR,  8'h00},
    '{CH_QUOTE,  1'b0,  0, KIND_BYTE, 8'h00},
    '{CH_BSLASH, 1'b0,  0, KIND_BYTE, 8'h00},
    '{8'h71,     1'b0,  1, KIND_ERR,  8'h00},
    '{8'h00,     1'b1,  0, KIND_BYTE, 8'h00}
  };

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    return -1;
  endfunction

  function automatic logic [8:0] esc_target(logic [7:0] c);
    case (c)
      CH_QUOTE:  return {1'b0, CH_QUOTE};
      CH_BSLASH: return {1'b0, CH_BSLASH};
      CH_SLASH:  return {1'b0, CH_SLASH};
      CH_B:      return 9'h008;
      CH_F:      return 9'h00C;
      CH_N:      return 9'h00A;
      CH_R:      return 9'h00D;
      CH_T:      return 9'h009;
      default:   return NO_ESCAPE;
    endcase
  endfunction

  function automatic void add_result(logic [7:0] v, kind_t k);
    result_t r;
    r.value = v;
    r.kind  = k;
    r.last  = 1'b0;
    fresh.insert(fresh.size(), r);
  endfunction

  function automatic void go_error();
    dec_mode = MODE_ERR;
    add_result(8'h00, KIND_ERR);
  endfunction

  // Decodes one request into fresh[] and advances the decoder state.
  function automatic void decode_request(logic [7:0] c, logic eot);
    logic [8:0] esc;
    int         nib;
    fresh.delete();
    if (eot) begin
      if (dec_mode == MODE_STR || dec_mode == MODE_ESC || dec_mode == MODE_HEX) begin
        add_result(8'h00, KIND_ERR);
      end
      dec_mode  = MODE_IDLE;
      hex_taken = '0;
      code_pt   = '0;
    end else begin
      case (dec_mode)
        MODE_IDLE: begin
          if (c == CH_QUOTE) dec_mode = MODE_STR;
          else if (!is_blank(c)) go_error();
        end
        MODE_STR: begin
          if (c == CH_QUOTE) begin
            dec_mode = MODE_IDLE;
            add_result(8'h00, KIND_DONE);
          end else if (c < CH_SPACE) begin
            go_error();
          end else if (c == CH_BSLASH) begin
            dec_mode = MODE_ESC;
          end else begin
            add_result(c, KIND_BYTE);
          end
        end
        MODE_ESC: begin
          esc = esc_target(c);
          if (c == CH_U) begin
            dec_mode  = MODE_HEX;
            hex_taken = '0;
            code_pt   = '0;
          end else if (esc == NO_ESCAPE) begin
            go_error();
          end else begin
            dec_mode = MODE_STR;
            add_result(esc[7:0], KIND_BYTE);
          end
        end
        MODE_HEX: begin
          nib = hex_nibble(c);
          if (nib < 0) begin
            go_error();
          end else begin
            code_pt = {code_pt[11:0], nib[3:0]};
            if (hex_taken != HEX_LAST) begin
              hex_taken = hex_taken + 2'd1;
            end else begin
              hex_taken = '0;
              if (code_pt >= 16'hD800 && code_pt <= 16'hDFFF) begin
                go_error();
              end else begin
                dec_mode = MODE_STR;
                if (code_pt <= 16'h007F) begin
                  add_result(code_pt[7:0], KIND_BYTE);
                end else if (code_pt <= 16'h07FF) begin
                  add_result({3'b110, code_pt[10:6]}, KIND_BYTE);
                  add_result({2'b10, code_pt[5:0]}, KIND_BYTE);
                end else begin
                  add_result({4'b1110, code_pt[15:12]}, KIND_BYTE);
                  add_result({2'b10, code_pt[11:6]}, KIND_BYTE);
                  add_result({2'b10, code_pt[5:0]}, KIND_BYTE);
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_text(logic [7:0] c, logic eot = 1'b0, bit live = 1'b1);
    text_item_t it;
    it.ch      = c;
    it.eot     = eot;
    it.typed_n = -1;
    it.tkind   = KIND_BYTE;
    it.tval    = 8'h00;
    text_q.insert(text_q.size(), it);
    if (live) live_items++;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  // backslash, u, then the leading digits of code
  function automatic void push_unicode(logic [15:0] code, int digits);
    add_text(CH_BSLASH);
    add_text(CH_U);
    for (int i = 0; i < digits; i++) add_text(hex_char(code[15 - 4 * i -: 4]));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  // scoreboard
  always @(posedge clk) begin : bus_watch
    text_item_t it;
    result_t    want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        decode_request(in_ch.in_byte, in_ch.end_of_text);
        it = text_q[taken];
        taken++;
        if (it.typed_n < 0) begin
          foreach (fresh[i]) decoded_q.insert(decoded_q.size(), fresh[i]);
        end else if (it.typed_n == 1) begin
          want.value = it.tval;
          want.kind  = it.tkind;
          want.last  = 1'b1;
          decoded_q.insert(decoded_q.size(), want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result: value %02h kind %0d last %b", $time,
                   out_ch.out_byte, out_ch.kind, out_ch.last_of_run);
          failures++;
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.value || out_ch.kind !== want.kind ||
              out_ch.last_of_run !== want.last) begin
            $display("%0t: mismatch: expected value %02h kind %0d last %b, got value %02h kind %0d last %b",
                     $time, want.value, want.kind, want.last,
                     out_ch.out_byte, out_ch.kind, out_ch.last_of_run);
            failures++;
          end
          case (want.kind)
            KIND_BYTE: n_bytes++;
            KIND_DONE: n_closed++;
            default:   n_errors++;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles == STALL_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stall styles, one long hold-off
  initial begin
    int         cyc;
    int         style;
    logic [7:0] mask;
    cyc   = 0;
    style = 0;
    mask  = 8'hFF;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (cyc == HOLD_AT) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
      end
      if (cyc % 40 == 0) begin
        style = $urandom_range(0, 2);
        mask  = 8'($urandom);
      end
      case (style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= mask[cyc % 8];
      endcase
      @(posedge clk);
      cyc++;
    end
  end

  initial begin
    int          idx;
    int          burst;
    int          flaw;
    logic [7:0]  c;
    logic [15:0] code;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.end_of_text <= 1'b0;

    foreach (directed_rows[i]) text_q.insert(text_q.size(), directed_rows[i]);

    // mostly well-formed strings, the rest broken ones, each ending back in idle
    while (live_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        repeat ($urandom_range(0, 2)) begin
          c = 8'($urandom_range(8'h08, 8'h0D));
          add_text((c == 8'h08) ? CH_SPACE : c);
        end
        add_text(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(0, 5))
            0, 1, 2: add_text(plain_byte());
            3: begin
              case ($urandom_range(0, 7))
                0:       c = CH_QUOTE;
                1:       c = CH_BSLASH;
                2:       c = CH_SLASH;
                3:       c = CH_B;
                4:       c = CH_F;
                5:       c = CH_N;
                6:       c = CH_R;
                default: c = CH_T;
              endcase
              add_text(CH_BSLASH);
              add_text(c);
            end
            default: begin
              case ($urandom_range(0, 9))
                0: begin
                  case ($urandom_range(0, 6))
                    0:       code = 16'h007F;
                    1:       code = 16'h0080;
                    2:       code = 16'h07FF;
                    3:       code = 16'h0800;
                    4:       code = 16'hD7FF;
                    5:       code = 16'hE000;
                    default: code = 16'hFFFF;
                  endcase
                end
                1, 2, 3: code = 16'($urandom_range(16'h0000, 16'h007F));
                4, 5, 6: code = 16'($urandom_range(16'h0080, 16'h07FF));
                default: begin
                  code = 16'($urandom_range(16'h0800, 16'hFFFF));
                  if (code >= 16'hD800 && code <= 16'hDFFF) code = code ^ 16'h4000;
                end
              endcase
              push_unicode(code, 4);
            end
          endcase
        end
        add_text(CH_QUOTE);
        if ($urandom_range(0, 3) == 0) add_text(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        flaw = $urandom_range(0, 7);
        if (flaw != 7) begin
          add_text(CH_QUOTE);
          repeat ($urandom_range(0, 3)) add_text(plain_byte());
        end
        case (flaw)
          0: add_text(8'($urandom_range(8'h00, 8'h1F)));
          1: begin
            add_text(CH_BSLASH);
            do c = 8'($urandom_range(0, 255));
            while (c == CH_U || esc_target(c) != NO_ESCAPE);
            add_text(c);
          end
          2: begin
            push_unicode(16'($urandom), $urandom_range(0, 3));
            do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
            add_text(c);
          end
          3: push_unicode(16'($urandom_range(16'hD800, 16'hDFFF)), 4);
          4: ;
          5: add_text(CH_BSLASH);
          6: push_unicode(16'($urandom), $urandom_range(0, 3));
          default: begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || is_blank(c));
            add_text(c);
          end
        endcase
        // noise after an error is dropped by the block
        if (flaw < 4 || flaw == 7) begin
          repeat ($urandom_range(0, 4)) add_text(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        add_text(8'($urandom_range(0, 255)), 1'b1);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    while (idx < text_q.size()) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      while (burst > 0 && idx < text_q.size()) begin
        in_ch.in_byte     <= text_q[idx].ch;
        in_ch.end_of_text <= text_q[idx].eot;
        in_ch.valid       <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        idx++;
        burst--;
      end
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end

    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (decoded_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
      failures++;
    end
    $display("Decoded %0d requests (%0d directed) into %0d bytes, %0d closed strings, %0d errors;",
             taken, N_DIRECTED, n_bytes, n_closed, n_errors);
    $display("escapes, \\u to 1-3 byte UTF-8, surrogates, bad hex, end of text in every mode.");
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/jsu_pkg.sv
src/jsu_in_if.sv
src/jsu_out_if.sv
src/json_string_unescape_utf8.sv
tb/sv/json_string_unescape_utf8_tb.sv
